@@ rtl/bscc_pkg.sv @@
// Shared types, constants and the weight table for the bright spot centroid block.
`timescale 1ns / 1ps
package bscc_pkg;

    localparam int MAX_DIM      = 256;
    localparam int DIM_BITS     = $clog2(MAX_DIM);
    localparam int ADDR_BITS    = 2 * DIM_BITS;
    localparam int CFG_DIM_BITS = 9;
    localparam int RADIUS_BITS  = 4;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int WEIGHT_BITS  = 32;
    localparam int LUT_BITS     = 32;
    localparam int LUT_SIZE     = 766;
    localparam int SUM_BITS     = 10;
    localparam int WT_BITS      = 48;
    localparam int WXY_BITS     = 56;
    localparam int PROD_BITS    = WEIGHT_BITS + DIM_BITS;
    localparam int CHAN_BITS    = 8;
    localparam int CSUM_BITS    = 18;
    localparam int CNT_BITS     = 10;
    localparam int MEAN_BITS    = 16;
    localparam int MREM_BITS    = CSUM_BITS + CHAN_BITS;
    localparam int STEP_BITS    = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [CFG_DIM_BITS-1:0] RST_IMAGE_WIDTH   = 9'd256;
    localparam logic [CFG_DIM_BITS-1:0] RST_IMAGE_HEIGHT  = 9'd256;
    localparam logic [RADIUS_BITS-1:0]  RST_WINDOW_RADIUS = 4'd8;

    localparam logic [STEP_BITS-1:0] CENT_STEPS = STEP_BITS'(DIM_BITS - 1);
    localparam logic [STEP_BITS-1:0] MEAN_STEPS = STEP_BITS'(MEAN_BITS - 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  centroid_x;
        logic [7:0]  centroid_y;
        logic [15:0] mean_red;
        logic [15:0] mean_green;
        logic [15:0] mean_blue;
        logic        no_bright_pixels;
    } result_t;

    typedef struct packed {
        logic [CFG_DIM_BITS-1:0] image_width;
        logic [CFG_DIM_BITS-1:0] image_height;
        logic [RADIUS_BITS-1:0]  window_radius;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_RUN,
        ST_DRAIN,
        ST_CINIT,
        ST_CSTEP,
        ST_WSETUP,
        ST_WSCAN,
        ST_WTAIL,
        ST_MINIT,
        ST_MSTEP,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic cent_init;
        logic cent_step;
        logic win_setup;
        logic win_read;
        logic mean_init;
        logic mean_step;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic sums_ready;
        logic win_empty;
        logic scan_last;
    } dp_status_t;

    typedef logic [LUT_BITS-1:0] weight_lut_t [LUT_SIZE];

    // round((s/765)^10 * 2^32), saturated; evaluated at elaboration only
    function automatic weight_lut_t build_lut();
        weight_lut_t  lut;
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] t;
        logic [63:0]  q;
        for (int s = 0; s < LUT_SIZE; s++) begin
            num = 192'd1;
            den = 192'd1;
            for (int k = 0; k < 10; k++) begin
                num = num * 192'(s);
                den = den * 192'd765;
            end
            num = num << 32;
            q = '0;
            for (int k = 32; k >= 0; k--) begin
                t = den << k;
                if (t <= num) begin
                    num = num - t;
                    q[k] = 1'b1;
                end
            end
            if ((num << 1) >= den) q = q + 64'd1;
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            lut[s] = q[LUT_BITS-1:0];
        end
        return lut;
    endfunction

    // last valid index of a dimension, register clamped to 1..MAX_DIM
    function automatic logic [DIM_BITS-1:0] dim_last(input logic [CFG_DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > MAX_DIM)
            r = DIM_BITS'(MAX_DIM - 1);
        else
            r = DIM_BITS'(v - 1'b1);
        return r;
    endfunction

endpackage

@@ rtl/bright_spot_centroid_color.sv @@
// Top level: configuration registers, result register, controller and datapath.
// Throughput: one pixel beat per cycle while an image streams in.
// Stall: after the beat marked last_pixel, input stays stalled through the drain, the
//   centroid division, the window scan over the in-bounds window pixels (up to 961)
//   and the mean division, and while an earlier result beat still waits downstream;
//   the one-bit-per-cycle dividers and the single read port of the pixel store set its length.
// Reset: image sums, intake counters and control clear; registers go to 256, 256, 8; store undefined.
`timescale 1ns / 1ps
module bright_spot_centroid_color
    import bscc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    pixel_valid,
    output logic                    pixel_stall,
    input  pixel_t                  pixel,
    output logic                    result_valid,
    input  logic                    result_stall,
    output result_t                 result
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    dp_result;
    result_t    result_reg;
    logic       result_valid_reg;
    logic       take_pixel;
    logic       out_load;
    logic       out_free;

    // configuration writes must arrive only between images (the block does not enforce this); unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= RST_IMAGE_WIDTH;
            cfg_reg.image_height  <= RST_IMAGE_HEIGHT;
            cfg_reg.window_radius <= RST_WINDOW_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data;
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data;
                REG_WINDOW_RADIUS: cfg_reg.window_radius <= cfg_data[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // the result register frees the controller once loaded; the next image
    // streams in while a result beat still waits downstream
    assign out_free     = !result_valid_reg || !result_stall;
    assign pixel_stall  = !take_pixel;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            result_reg <= dp_result;
    end

    bscc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .last_pixel  (pixel.last_pixel),
        .out_free    (out_free),
        .status      (status),
        .cmd         (cmd),
        .take_pixel  (take_pixel),
        .out_load    (out_load)
    );

    bscc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pixel  (pixel),
        .cmd    (cmd),
        .status (status),
        .result (dp_result)
    );

endmodule

@@ rtl/bscc_ctrl.sv @@
// Sequencer for pixel intake, centroid division, window scan and mean division.
`timescale 1ns / 1ps
module bscc_ctrl
    import bscc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    input  logic       last_pixel,
    input  logic       out_free,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       take_pixel,
    output logic       out_load
);

    ctrl_state_t          state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:    if (pixel_valid && last_pixel) state_next = ST_DRAIN;
            ST_DRAIN:  if (status.sums_ready) state_next = ST_CINIT;
            ST_CINIT:  state_next = ST_CSTEP;
            ST_CSTEP:  if (step_reg == '0) state_next = ST_WSETUP;
            ST_WSETUP: state_next = ST_WSCAN;
            ST_WSCAN:
            begin
                if (status.win_empty) state_next = ST_MINIT;
                else if (status.scan_last) state_next = ST_WTAIL;
            end
            ST_WTAIL:  state_next = ST_MINIT;
            ST_MINIT:  state_next = ST_MSTEP;
            ST_MSTEP:  if (step_reg == '0) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_RUN;
            default:   state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_CINIT: step_next = CENT_STEPS;
            ST_MINIT: step_next = MEAN_STEPS;
            ST_CSTEP,
            ST_MSTEP: step_next = step_reg - 1'b1;
            default:  step_next = step_reg;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        take_pixel    = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                take_pixel = 1'b1;
                cmd.accept = pixel_valid;
            end
            ST_CINIT:  cmd.cent_init = 1'b1;
            ST_CSTEP:  cmd.cent_step = 1'b1;
            ST_WSETUP: cmd.win_setup = 1'b1;
            ST_WSCAN:  cmd.win_read  = !status.win_empty;
            ST_MINIT:  cmd.mean_init = 1'b1;
            ST_MSTEP:  cmd.mean_step = 1'b1;
            ST_OUT:
            begin
                out_load  = out_free;
                cmd.clear = out_free;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/bscc_datapath.sv @@
// Pixel store, weight pipeline, accumulators, dividers and window scan.
`timescale 1ns / 1ps
module bscc_datapath
    import bscc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  pixel_t     pixel,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output result_t    result
);

    localparam weight_lut_t WEIGHT_LUT = build_lut();

    logic [3*CHAN_BITS-1:0] store [MAX_DIM*MAX_DIM];

    logic [DIM_BITS-1:0] wlast, hlast;
    assign wlast = dim_last(cfg.image_width);
    assign hlast = dim_last(cfg.image_height);

    // intake counters and weight pipeline
    logic [DIM_BITS-1:0]    col_reg, row_reg;
    logic [SUM_BITS-1:0]    csum;
    logic [WEIGHT_BITS-1:0] w1_reg, w2_reg;
    logic [DIM_BITS-1:0]    x1_reg, y1_reg;
    logic                   v1_reg, v2_reg, last1_reg, last2_reg;
    logic [PROD_BITS-1:0]   px2_reg, py2_reg;
    logic [LUT_BITS-1:0]    lut_word;

    assign csum = SUM_BITS'(pixel.red) + SUM_BITS'(pixel.green) + SUM_BITS'(pixel.blue);
    assign lut_word = WEIGHT_LUT[csum];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            last1_reg <= 1'b0;
            last2_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= cmd.accept;
            last1_reg <= cmd.accept && pixel.last_pixel;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            if (cmd.accept)
            begin
                if (pixel.last_pixel)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (row_reg >= hlast)
                begin
                    row_reg <= '0;
                    col_reg <= (col_reg >= wlast) ? '0 : col_reg + 1'b1;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store[{col_reg, row_reg}] <= {pixel.blue, pixel.green, pixel.red};
            w1_reg <= lut_word[LUT_BITS-1 -: WEIGHT_BITS];
            x1_reg <= col_reg;
            y1_reg <= row_reg;
        end
        w2_reg  <= w1_reg;
        px2_reg <= w1_reg * x1_reg;
        py2_reg <= w1_reg * y1_reg;
    end

    // image totals
    logic [WT_BITS-1:0]  wt_reg;
    logic [WXY_BITS-1:0] wx_reg, wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg <= '0;
            wx_reg <= '0;
            wy_reg <= '0;
        end
        else if (cmd.clear)
        begin
            wt_reg <= '0;
            wx_reg <= '0;
            wy_reg <= '0;
        end
        else if (v2_reg)
        begin
            wt_reg <= wt_reg + WT_BITS'(w2_reg);
            wx_reg <= wx_reg + WXY_BITS'(px2_reg);
            wy_reg <= wy_reg + WXY_BITS'(py2_reg);
        end
    end

    assign status.sums_ready = v2_reg && last2_reg;

    // centroid: restoring division, one quotient bit per cycle
    logic [WXY_BITS-1:0] remx_reg, remy_reg, cdiv_reg;
    logic [DIM_BITS-1:0] qx_reg, qy_reg;
    logic                satx_reg, saty_reg, zero_reg;
    logic [WXY_BITS-1:0] wt_full;

    assign wt_full = {wt_reg, {(WXY_BITS-WT_BITS){1'b0}}} >> (WXY_BITS - WT_BITS - DIM_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.cent_init)
        begin
            remx_reg <= wx_reg;
            remy_reg <= wy_reg;
            cdiv_reg <= wt_full >> 1;
            qx_reg   <= '0;
            qy_reg   <= '0;
            satx_reg <= wx_reg >= wt_full;
            saty_reg <= wy_reg >= wt_full;
            zero_reg <= wt_reg == '0;
        end
        else if (cmd.cent_step)
        begin
            cdiv_reg <= cdiv_reg >> 1;
            if (remx_reg >= cdiv_reg)
            begin
                remx_reg <= remx_reg - cdiv_reg;
                qx_reg   <= {qx_reg[DIM_BITS-2:0], 1'b1};
            end
            else
            begin
                qx_reg <= {qx_reg[DIM_BITS-2:0], 1'b0};
            end
            if (remy_reg >= cdiv_reg)
            begin
                remy_reg <= remy_reg - cdiv_reg;
                qy_reg   <= {qy_reg[DIM_BITS-2:0], 1'b1};
            end
            else
            begin
                qy_reg <= {qy_reg[DIM_BITS-2:0], 1'b0};
            end
        end
    end

    // window bounds
    logic [DIM_BITS-1:0] cx, cy, rad, xlo, ylo, xhi, yhi;
    logic [DIM_BITS:0]   xhi_raw, yhi_raw;

    assign rad = DIM_BITS'(cfg.window_radius);
    assign cx  = zero_reg ? '0 : (satx_reg ? {DIM_BITS{1'b1}} : qx_reg);
    assign cy  = zero_reg ? '0 : (saty_reg ? {DIM_BITS{1'b1}} : qy_reg);
    assign xlo = (cx >= rad) ? cx - rad : '0;
    assign ylo = (cy >= rad) ? cy - rad : '0;
    assign xhi_raw = {1'b0, cx} + {1'b0, rad};
    assign yhi_raw = {1'b0, cy} + {1'b0, rad};
    assign xhi = (xhi_raw > {1'b0, wlast}) ? wlast : xhi_raw[DIM_BITS-1:0];
    assign yhi = (yhi_raw > {1'b0, hlast}) ? hlast : yhi_raw[DIM_BITS-1:0];

    logic [DIM_BITS-1:0]    cx_reg, cy_reg, px_reg, py_reg, ylo_reg, xhi_reg, yhi_reg;
    logic                   empty_reg, rdv_reg;
    logic [3*CHAN_BITS-1:0] rd_reg;
    logic [CSUM_BITS-1:0]   sr_reg, sg_reg, sb_reg;
    logic [CNT_BITS-1:0]    cnt_reg;

    assign status.win_empty = empty_reg;
    assign status.scan_last = (px_reg == xhi_reg) && (py_reg == yhi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rdv_reg <= 1'b0;
        else
            rdv_reg <= cmd.win_read;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_setup)
        begin
            cx_reg    <= cx;
            cy_reg    <= cy;
            px_reg    <= xlo;
            py_reg    <= ylo;
            ylo_reg   <= ylo;
            xhi_reg   <= xhi;
            yhi_reg   <= yhi;
            empty_reg <= (xlo > xhi) || (ylo > yhi);
        end
        else if (cmd.win_read)
        begin
            if (py_reg == yhi_reg)
            begin
                py_reg <= ylo_reg;
                px_reg <= px_reg + 1'b1;
            end
            else
            begin
                py_reg <= py_reg + 1'b1;
            end
        end
        if (cmd.win_read)
            rd_reg <= store[{px_reg, py_reg}];
        if (cmd.win_setup)
        begin
            sr_reg  <= '0;
            sg_reg  <= '0;
            sb_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (rdv_reg)
        begin
            sr_reg  <= sr_reg + CSUM_BITS'(rd_reg[CHAN_BITS-1:0]);
            sg_reg  <= sg_reg + CSUM_BITS'(rd_reg[2*CHAN_BITS-1:CHAN_BITS]);
            sb_reg  <= sb_reg + CSUM_BITS'(rd_reg[3*CHAN_BITS-1:2*CHAN_BITS]);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // window means: (sum*256 + cnt/2) / cnt, one quotient bit per cycle
    logic [MREM_BITS-1:0] rr_reg, rg_reg, rb_reg, mdiv_reg, half;
    logic [MEAN_BITS-1:0] qr_reg, qg_reg, qb_reg;

    assign half = MREM_BITS'(cnt_reg >> 1);

    always_ff @(posedge clk)
    begin
        if (cmd.mean_init)
        begin
            rr_reg   <= {sr_reg, {CHAN_BITS{1'b0}}} + half;
            rg_reg   <= {sg_reg, {CHAN_BITS{1'b0}}} + half;
            rb_reg   <= {sb_reg, {CHAN_BITS{1'b0}}} + half;
            mdiv_reg <= MREM_BITS'(cnt_reg) << (MEAN_BITS - 1);
            qr_reg   <= '0;
            qg_reg   <= '0;
            qb_reg   <= '0;
        end
        else if (cmd.mean_step)
        begin
            mdiv_reg <= mdiv_reg >> 1;
            if (rr_reg >= mdiv_reg)
            begin
                rr_reg <= rr_reg - mdiv_reg;
                qr_reg <= {qr_reg[MEAN_BITS-2:0], 1'b1};
            end
            else
            begin
                qr_reg <= {qr_reg[MEAN_BITS-2:0], 1'b0};
            end
            if (rg_reg >= mdiv_reg)
            begin
                rg_reg <= rg_reg - mdiv_reg;
                qg_reg <= {qg_reg[MEAN_BITS-2:0], 1'b1};
            end
            else
            begin
                qg_reg <= {qg_reg[MEAN_BITS-2:0], 1'b0};
            end
            if (rb_reg >= mdiv_reg)
            begin
                rb_reg <= rb_reg - mdiv_reg;
                qb_reg <= {qb_reg[MEAN_BITS-2:0], 1'b1};
            end
            else
            begin
                qb_reg <= {qb_reg[MEAN_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        result.centroid_x       = 8'(cx_reg);
        result.centroid_y       = 8'(cy_reg);
        result.mean_red         = (cnt_reg == '0) ? '0 : qr_reg;
        result.mean_green       = (cnt_reg == '0) ? '0 : qg_reg;
        result.mean_blue        = (cnt_reg == '0) ? '0 : qb_reg;
        result.no_bright_pixels = zero_reg;
    end

endmodule
